/* rtl/core/lgcs_pkg.sv */
// lgcs_pkg: shared types, constants and the life rule for the column stream unit
// used by lgcs_cell, lgcs_out_queue and life_generation_column_stream_unit
`timescale 1ns / 1ps
`default_nettype none

package lgcs_pkg;

  localparam int INDEX_W     = 5;
  localparam int COLUMN_W    = 25;
  localparam int QUEUE_DEPTH = 4;
  localparam int QCNT_W      = 3;
  localparam int BIRTH_COUNT = 3;
  localparam int KEEP_COUNT  = 2;

  // results per accepted column
  localparam logic [1:0] PUSH_NONE   = 2'd0;
  localparam logic [1:0] PUSH_ONE    = 2'd1;
  localparam logic [1:0] PUSH_THREE  = 2'd3;

  // result slots produced by every cell
  localparam int RES_MID   = 0;
  localparam int RES_LAST  = 1;
  localparam int RES_WRAP  = 2;

  typedef struct packed {
    logic [INDEX_W-1:0]  column_index;
    logic [COLUMN_W-1:0] next_column;
    logic                generation_done;
  } result_t;

  // what a cell shows to the cells above and below it
  typedef struct packed {
    logic first;
    logic second;
    logic older;
    logic newer;
    logic col;
  } cell_view_t;

  typedef struct packed {
    logic accept;
    logic load_first;
    logic load_second;
  } cell_ctl_t;

  // bit 0 is the row above, bit 1 the row itself, bit 2 the row below
  function automatic logic life_next(logic [2:0] left, logic [2:0] mid,
                                     logic [2:0] right);
    logic [3:0] n;
    n = 4'(left[0]) + 4'(left[1]) + 4'(left[2]) + 4'(mid[0]) + 4'(mid[2])
      + 4'(right[0]) + 4'(right[1]) + 4'(right[2]);
    if (n == 4'(BIRTH_COUNT)) begin
      return 1'b1;
    end else if (n == 4'(KEEP_COUNT)) begin
      return mid[1];
    end
    return 1'b0;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/lgcs_cell.sv */
// lgcs_cell: one grid row, holds that row's bits of the kept and window columns
// and evaluates the life rule from its own bits and its two neighbors; uses lgcs_pkg
`timescale 1ns / 1ps
`default_nettype none

module lgcs_cell (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_bit,
  input  wire lgcs_pkg::cell_ctl_t ctl,
  input  wire lgcs_pkg::cell_view_t view_up,
  input  wire lgcs_pkg::cell_view_t view_dn,
  output lgcs_pkg::cell_view_t     view,
  output logic [2:0]               res
);

  logic first_r,  first_nxt;
  logic second_r, second_nxt;
  logic older_r,  older_nxt;
  logic newer_r,  newer_nxt;

  always_comb begin
    view.first  = first_r;
    view.second = second_r;
    view.older  = older_r;
    view.newer  = newer_r;
    view.col    = in_bit;
  end

  // window column evaluated against the incoming column
  assign res[lgcs_pkg::RES_MID] = lgcs_pkg::life_next(
      {view_dn.older, older_r, view_up.older},
      {view_dn.newer, newer_r, view_up.newer},
      {view_dn.col,   in_bit,  view_up.col});
  // last column wraps onto column 0
  assign res[lgcs_pkg::RES_LAST] = lgcs_pkg::life_next(
      {view_dn.newer, newer_r, view_up.newer},
      {view_dn.col,   in_bit,  view_up.col},
      {view_dn.first, first_r, view_up.first});
  // column 0 between the last column and column 1
  assign res[lgcs_pkg::RES_WRAP] = lgcs_pkg::life_next(
      {view_dn.col,    in_bit,   view_up.col},
      {view_dn.first,  first_r,  view_up.first},
      {view_dn.second, second_r, view_up.second});

  always_comb begin
    first_nxt  = first_r;
    second_nxt = second_r;
    older_nxt  = older_r;
    newer_nxt  = newer_r;
    if (ctl.accept) begin
      if (ctl.load_first) begin
        first_nxt = in_bit;
      end
      if (ctl.load_second) begin
        second_nxt = in_bit;
      end
      older_nxt = newer_r;
      newer_nxt = in_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r  <= 1'b0;
      second_r <= 1'b0;
      older_r  <= 1'b0;
      newer_r  <= 1'b0;
    end else begin
      first_r  <= first_nxt;
      second_r <= second_nxt;
      older_r  <= older_nxt;
      newer_r  <= newer_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/lgcs_out_queue.sv */
// lgcs_out_queue: small in-order result queue, up to three pushes and one pop a cycle
// head entry drives the result ports directly; uses lgcs_pkg
`timescale 1ns / 1ps
`default_nettype none

module lgcs_out_queue (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic [1:0]                      push_n,
  input  wire lgcs_pkg::result_t [2:0]         push_data,
  input  wire logic                            out_ready,
  output logic                                 out_valid,
  output lgcs_pkg::result_t                    head,
  output logic [lgcs_pkg::QCNT_W-1:0]          free_cnt
);

  lgcs_pkg::result_t q_r   [lgcs_pkg::QUEUE_DEPTH];
  lgcs_pkg::result_t q_nxt [lgcs_pkg::QUEUE_DEPTH];
  logic [lgcs_pkg::QCNT_W-1:0] count_r, count_nxt;
  logic [lgcs_pkg::QCNT_W-1:0] base;
  logic                        pop;

  assign out_valid = (count_r != '0);
  assign head      = q_r[0];
  assign free_cnt  = lgcs_pkg::QCNT_W'(lgcs_pkg::QUEUE_DEPTH) - count_r;
  assign pop       = out_valid && out_ready;
  assign base      = count_r - lgcs_pkg::QCNT_W'(pop);
  assign count_nxt = base + lgcs_pkg::QCNT_W'(push_n);

  always_comb begin
    for (int i = 0; i < lgcs_pkg::QUEUE_DEPTH; i++) begin
      q_nxt[i] = q_r[i];
    end
    if (pop) begin
      for (int i = 0; i < lgcs_pkg::QUEUE_DEPTH - 1; i++) begin
        q_nxt[i] = q_r[i + 1];
      end
    end
    for (int i = 0; i < lgcs_pkg::QUEUE_DEPTH; i++) begin
      for (int k = 0; k < 3; k++) begin
        if ((2'(k) < push_n) && (base + lgcs_pkg::QCNT_W'(k) == lgcs_pkg::QCNT_W'(i))) begin
          q_nxt[i] = push_data[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < lgcs_pkg::QUEUE_DEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/life_generation_column_stream_unit.sv */
// life_generation_column_stream_unit: one generation of toroidal B3/S23 life per column stream
// built from lgcs_cell (one per grid row) and lgcs_out_queue; uses lgcs_pkg
`timescale 1ns / 1ps
`default_nettype none

// Columns of the current generation enter one per transaction, column 0 first, bit y
// being row y; bits at or above GRID_ROWS are dropped. A row of GRID_ROWS cells keeps
// columns 0 and 1 and the two latest columns, and every cell evaluates its row in the
// same cycle the column is taken, so a column is accepted every clock while the queue
// has room. The first two columns of a generation give no result, each later column
// gives next-generation column x-1, and the last column gives three: the column before
// it, itself, and column 0 with generation_done set. Results leave in order from a
// registered four-entry queue; GRID_COLUMNS columns in yield GRID_COLUMNS results
// out, so the sustained rate is one column per cycle while the result side keeps up.
// in_ready drops only when the queue lacks room for the results of the waiting column.
module life_generation_column_stream_unit #(
  parameter int GRID_COLUMNS = 25,
  parameter int GRID_ROWS    = 25
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [lgcs_pkg::COLUMN_W-1:0]   in_column_bits,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [lgcs_pkg::INDEX_W-1:0]         out_column_index,
  output logic [lgcs_pkg::COLUMN_W-1:0]        out_next_column,
  output logic                                 out_generation_done
);

  localparam int CW = $clog2(GRID_COLUMNS);
  localparam int IW = lgcs_pkg::INDEX_W;
  localparam int XW = lgcs_pkg::COLUMN_W;

  logic [CW-1:0] seen_r, seen_nxt;
  logic [CW-1:0] seen_dec;
  logic          is_last;
  logic          accept;
  logic [1:0]    need;
  logic [1:0]    push_n;

  logic [GRID_ROWS-1:0]      col;
  logic [GRID_ROWS+XW-1:0]   col_ext;
  logic [GRID_ROWS-1:0]      res_mid, res_last, res_wrap;
  logic [GRID_ROWS+XW-1:0]   mid_ext, last_ext, wrap_ext;
  logic [CW+IW-1:0]          mid_idx_ext, last_idx_ext;

  lgcs_pkg::cell_ctl_t          ctl;
  lgcs_pkg::cell_view_t         views [GRID_ROWS];
  lgcs_pkg::result_t [2:0]      push_data;
  lgcs_pkg::result_t            head;
  logic [lgcs_pkg::QCNT_W-1:0]  free_cnt;

  assign col_ext = {{GRID_ROWS{1'b0}}, in_column_bits};
  assign col     = col_ext[GRID_ROWS-1:0];

  assign is_last = (seen_r == CW'(GRID_COLUMNS - 1));
  assign need    = (seen_r < CW'(2)) ? lgcs_pkg::PUSH_NONE :
                   (is_last ? lgcs_pkg::PUSH_THREE : lgcs_pkg::PUSH_ONE);
  assign in_ready = (free_cnt >= lgcs_pkg::QCNT_W'(need));
  assign accept   = in_valid && in_ready;
  assign push_n   = accept ? need : lgcs_pkg::PUSH_NONE;

  assign ctl.accept      = accept;
  assign ctl.load_first  = (seen_r == CW'(0));
  assign ctl.load_second = (seen_r == CW'(1));

  assign seen_dec = seen_r - CW'(1);
  assign seen_nxt = accept ? (is_last ? '0 : seen_r + CW'(1)) : seen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
    end else begin
      seen_r <= seen_nxt;
    end
  end

  for (genvar y = 0; y < GRID_ROWS; y++) begin : g_row
    localparam int UP = (y == 0) ? GRID_ROWS - 1 : y - 1;
    localparam int DN = (y == GRID_ROWS - 1) ? 0 : y + 1;
    logic [2:0] res;

    lgcs_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_bit  (col[y]),
      .ctl     (ctl),
      .view_up (views[UP]),
      .view_dn (views[DN]),
      .view    (views[y]),
      .res     (res)
    );

    assign res_mid[y]  = res[lgcs_pkg::RES_MID];
    assign res_last[y] = res[lgcs_pkg::RES_LAST];
    assign res_wrap[y] = res[lgcs_pkg::RES_WRAP];
  end

  assign mid_ext      = {{XW{1'b0}}, res_mid};
  assign last_ext     = {{XW{1'b0}}, res_last};
  assign wrap_ext     = {{XW{1'b0}}, res_wrap};
  assign mid_idx_ext  = {{IW{1'b0}}, seen_dec};
  assign last_idx_ext = {{IW{1'b0}}, seen_r};

  always_comb begin
    push_data[0].column_index    = mid_idx_ext[IW-1:0];
    push_data[0].next_column     = mid_ext[XW-1:0];
    push_data[0].generation_done = 1'b0;
    push_data[1].column_index    = last_idx_ext[IW-1:0];
    push_data[1].next_column     = last_ext[XW-1:0];
    push_data[1].generation_done = 1'b0;
    push_data[2].column_index    = '0;
    push_data[2].next_column     = wrap_ext[XW-1:0];
    push_data[2].generation_done = 1'b1;
  end

  lgcs_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (push_n),
    .push_data (push_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .head      (head),
    .free_cnt  (free_cnt)
  );

  assign out_column_index    = head.column_index;
  assign out_next_column     = head.next_column;
  assign out_generation_done = head.generation_done;

  a_seen_range: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r <= CW'(GRID_COLUMNS - 1))
    else $error("column counter past last column");

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_cnt <= lgcs_pkg::QCNT_W'(lgcs_pkg::QUEUE_DEPTH))
    else $error("result queue overfilled");

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept && is_last |=> out_valid)
    else $error("last column produced no result");

  a_done_is_col0: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_generation_done |-> out_column_index == '0)
    else $error("generation end on a column other than 0");

endmodule

`default_nettype wire

/* test/life_generation_column_stream_unit_tb.sv */
// life_generation_column_stream_unit_tb: self-checking bench for the life column stream unit
// streams generations of columns, predicts every next-generation column, compares in order
// depends on lgcs_pkg and life_generation_column_stream_unit
`timescale 1ns / 1ps

module life_generation_column_stream_unit_tb;

  localparam int COLUMN_W = lgcs_pkg::COLUMN_W;
  localparam int INDEX_W  = lgcs_pkg::INDEX_W;
  typedef lgcs_pkg::result_t result_t;

  localparam int COLS = 25;
  localparam int ROWS = 25;
  localparam logic [COLUMN_W-1:0] ROW_MASK = COLUMN_W'((64'd1 << ROWS) - 64'd1);
  localparam int RANDOM_GENERATIONS = 13;

  typedef enum int {
    FILL_HALF,
    FILL_QUARTER,
    FILL_EIGHTH,
    FILL_THREE_QUARTER,
    FILL_EXTREME
  } fill_t;

  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_MOSTLY,
    RX_SLUGGISH,
    RX_PERIODIC
  } rx_mode_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [COLUMN_W-1:0] in_column_bits = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [INDEX_W-1:0]  out_column_index;
  logic [COLUMN_W-1:0] out_next_column;
  logic                out_generation_done;

  // predictor state
  logic [COLUMN_W-1:0] gen_col0;
  logic [COLUMN_W-1:0] gen_col1;
  logic [COLUMN_W-1:0] win_older;
  logic [COLUMN_W-1:0] win_newer;
  int                  cols_taken;

  result_t pending_columns[$];
  int      error_count = 0;
  int      burst_left = 0;

  rx_mode_t   rx_mode = RX_ALWAYS;
  logic [5:0] rx_count = '0;

  life_generation_column_stream_unit #(
    .GRID_COLUMNS(COLS),
    .GRID_ROWS(ROWS)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_column_bits(in_column_bits),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_column_index(out_column_index),
    .out_next_column(out_next_column),
    .out_generation_done(out_generation_done)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #400000;
    $display("tb: failure");
    $finish;
  end

  // b3/s23 on one column, rows wrap top to bottom
  function automatic logic [COLUMN_W-1:0] evolve_column(input logic [COLUMN_W-1:0] left,
                                                        input logic [COLUMN_W-1:0] mid,
                                                        input logic [COLUMN_W-1:0] right);
    logic [COLUMN_W-1:0] res;
    int up;
    int dn;
    int n;
    res = '0;
    for (int y = 0; y < ROWS; y++) begin
      up = (y == 0) ? ROWS - 1 : y - 1;
      dn = (y == ROWS - 1) ? 0 : y + 1;
      n = left[up] + left[y] + left[dn] + mid[up] + mid[dn] + right[up] + right[y] + right[dn];
      if (n == 3) begin
        res[y] = 1'b1;
      end else if (n == 2) begin
        res[y] = mid[y];
      end
    end
    return res;
  endfunction

  function automatic result_t make_result(input int idx, input logic [COLUMN_W-1:0] col,
                                          input logic done);
    result_t r;
    r.column_index = INDEX_W'(idx);
    r.next_column = col;
    r.generation_done = done;
    return r;
  endfunction

  task automatic advance_life_stream(input logic [COLUMN_W-1:0] raw);
    logic [COLUMN_W-1:0] col;
    col = raw & ROW_MASK;
    if (cols_taken == 0) begin
      gen_col0 = col;
    end else if (cols_taken == 1) begin
      gen_col1 = col;
    end else begin
      pending_columns.push_back(make_result(cols_taken - 1,
                                            evolve_column(win_older, win_newer, col), 1'b0));
    end
    win_older = win_newer;
    win_newer = col;
    if (cols_taken + 1 >= COLS) begin
      pending_columns.push_back(make_result(cols_taken,
                                            evolve_column(win_older, win_newer, gen_col0), 1'b0));
      pending_columns.push_back(make_result(0,
                                            evolve_column(win_newer, gen_col0, gen_col1), 1'b1));
      cols_taken = 0;
    end else begin
      cols_taken = cols_taken + 1;
    end
  endtask

  // prediction and checking share one process so accept order is fixed
  always @(posedge clk) begin
    result_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        advance_life_stream(in_column_bits);
      end
      if (out_valid && out_ready) begin
        if (pending_columns.size() == 0) begin
          $display("%0t: result with nothing expected, got index %0d column %h done %b",
                   $time, out_column_index, out_next_column, out_generation_done);
          error_count++;
        end else begin
          want = pending_columns.pop_front();
          if (out_column_index !== want.column_index) begin
            $display("%0t: column_index expected %0d got %0d", $time,
                     want.column_index, out_column_index);
            error_count++;
          end
          if (out_next_column !== want.next_column) begin
            $display("%0t: next_column (index %0d) expected %h got %h", $time,
                     want.column_index, want.next_column, out_next_column);
            error_count++;
          end
          if (out_generation_done !== want.generation_done) begin
            $display("%0t: generation_done (index %0d) expected %b got %b", $time,
                     want.column_index, want.generation_done, out_generation_done);
            error_count++;
          end
        end
      end
    end
  end

  // receiver stalls, mode changes each time the 6-bit rx_count wraps
  always @(posedge clk) begin
    rx_count <= rx_count + 1'b1;
    if (rx_count == '0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
    end
    case (rx_mode)
      RX_ALWAYS:   out_ready <= 1'b1;
      RX_MOSTLY:   out_ready <= ($urandom_range(0, 9) < 7);
      RX_SLUGGISH: out_ready <= ($urandom_range(0, 3) == 0);
      default:     out_ready <= (rx_count[2:0] != 3'd0) && (rx_count[4:3] != 2'd2);
    endcase
  end

  task automatic send_column(input logic [COLUMN_W-1:0] bits);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_column_bits <= bits;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_columns.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [COLUMN_W-1:0] random_column(input fill_t fill);
    logic [COLUMN_W-1:0] c;
    case (fill)
      FILL_HALF:          c = COLUMN_W'($urandom);
      FILL_QUARTER:       c = COLUMN_W'($urandom & $urandom);
      FILL_EIGHTH:        c = COLUMN_W'($urandom & $urandom & $urandom);
      FILL_THREE_QUARTER: c = COLUMN_W'($urandom | $urandom);
      default: begin
        case ($urandom_range(0, 3))
          0:       c = '0;
          1:       c = '1;
          2:       c = COLUMN_W'(1) << $urandom_range(0, COLUMN_W - 1);
          default: c = ~(COLUMN_W'(1) << $urandom_range(0, COLUMN_W - 1));
        endcase
      end
    endcase
    return c;
  endfunction

  // one generation of hand-picked shapes: empty and full columns, wrap in both axes,
  // checkerboard, glider, blinker, block, lone cells
  task automatic test_directed_patterns();
    logic [COLUMN_W-1:0] shapes[COLS];
    shapes = '{
      25'h0000000, 25'h1FFFFFF, 25'h0000000, 25'h1000001, 25'h1000001,
      25'h1000001, 25'h0000000, 25'h1555555, 25'h0AAAAAA, 25'h0000004,
      25'h0000008, 25'h000000E, 25'h0000000, 25'h0001C00, 25'h0000000,
      25'h0300000, 25'h0300000, 25'h0000000, 25'h0001000, 25'h0000000,
      25'h0000020, 25'h0000060, 25'h0000000, 25'h1000003, 25'h1000001
    };
    foreach (shapes[i]) send_column(shapes[i]);
    wait_for_drain();
  endtask

  // sender holds off mid generation and again at its end until all results are out
  task automatic test_pause_mid_generation();
    for (int x = 0; x < COLS; x++) begin
      send_column(random_column(FILL_QUARTER));
      if (x == 9) begin
        wait_for_drain();
      end
    end
    wait_for_drain();
  endtask

  task automatic test_random_generations();
    fill_t fill;
    for (int g = 0; g < RANDOM_GENERATIONS; g++) begin
      fill = fill_t'($urandom_range(0, 4));
      for (int x = 0; x < COLS; x++) begin
        // an occasional odd column inside an otherwise uniform generation
        if ($urandom_range(0, 15) == 0) begin
          send_column(random_column(FILL_EXTREME));
        end else begin
          send_column(random_column(fill));
        end
      end
    end
  endtask

  initial begin
    gen_col0 = '0;
    gen_col1 = '0;
    win_older = '0;
    win_newer = '0;
    cols_taken = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_patterns();
    test_pause_mid_generation();
    test_random_generations();
    wait_for_drain();
    repeat (16) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
